// ===== sv/pde_pkg.sv =====
// shared types, constants and functions for the polynomial derivative evaluator
// no dependencies; imported by every module of the block
package pde_pkg;

   localparam int NUM_COEFFS_DEF = 8;
   localparam int REG_COUNT      = 8;
   localparam int CSR_IDX_W      = 3;
   localparam int DATA_W         = 32;
   localparam int ORDER_W        = 4;
   localparam int FACT_W         = 13;
   localparam int PROD_W         = 2 * DATA_W;
   localparam int SCALE_W        = DATA_W + FACT_W + 1;
   localparam int FRAC_BITS      = 16;
   localparam int REQ_DATA_W     = 40;

   localparam logic signed [DATA_W-1:0] S32_MAX = {1'b0, {(DATA_W-1){1'b1}}};
   localparam logic signed [DATA_W-1:0] S32_MIN = {1'b1, {(DATA_W-1){1'b0}}};

   typedef logic [CSR_IDX_W-1:0] coef_idx_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MUL,
      ST_ADD,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic clear;
      logic mul_en;
      logic add_en;
      logic out_load;
   } mac_ctrl_type;

   // k!/(k-d)! for d <= k < 8
   function automatic logic [FACT_W-1:0] falling_fact(input coef_idx_type k,
                                                       input logic [ORDER_W-1:0] d);
      int f;
      f = 1;
      for (int i = 1; i < REG_COUNT; i++) begin
         if ((i <= int'(k)) && (i + int'(d) > int'(k))) begin
            f = f * i;
         end
      end
      return f[FACT_W-1:0];
   endfunction

endpackage

// ===== sv/pde_coef_regs.sv =====
// coefficient register file, written from the csr channel, read by the sequencer index
// depends on pde_pkg
module pde_coef_regs
   import pde_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     wr_en,
   input  coef_idx_type             wr_idx,
   input  logic signed [DATA_W-1:0] wr_data,
   input  coef_idx_type             rd_idx,
   output logic signed [DATA_W-1:0] rd_data
);

   logic signed [DATA_W-1:0] coef_ff [REG_COUNT];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < REG_COUNT; i++) begin
            coef_ff[i] <= '0;
         end
      end else if (wr_en) begin
         coef_ff[wr_idx] <= wr_data;
      end
   end

   assign rd_data = coef_ff[rd_idx];

endmodule

// ===== sv/pde_mac.sv =====
// shared multiply and saturating accumulate unit for one horner step
// depends on pde_pkg
module pde_mac
   import pde_pkg::*;
(
   input  logic                     clock,
   input  mac_ctrl_type             ctrl,
   input  logic signed [DATA_W-1:0] x_in,
   input  logic signed [DATA_W-1:0] coef,
   input  logic [FACT_W-1:0]        fact,
   output logic signed [DATA_W-1:0] acc,
   output logic                     sat
);

   logic signed [DATA_W-1:0]  x_ff;
   logic signed [DATA_W-1:0]  acc_ff, acc_in;
   logic                      sat_ff, sat_in;
   logic signed [PROD_W-1:0]  prod_ff;
   logic signed [SCALE_W-1:0] scl_ff;

   logic signed [PROD_W-FRAC_BITS-1:0] prod_sh;
   logic                               prod_ovf, scl_ovf, sum_ovf;
   logic signed [DATA_W-1:0]           prod_clip, scl_clip;
   logic signed [DATA_W:0]             sum;
   logic signed [DATA_W-1:0]           sum_clip;

   always_comb begin
      // floor division by 2^16 is the upper part of the product
      prod_sh   = prod_ff[PROD_W-1:FRAC_BITS];
      prod_ovf  = prod_sh[PROD_W-FRAC_BITS-1:DATA_W-1] !=
                  {(PROD_W-FRAC_BITS-DATA_W+1){prod_sh[PROD_W-FRAC_BITS-1]}};
      prod_clip = prod_ovf ? (prod_sh[PROD_W-FRAC_BITS-1] ? S32_MIN : S32_MAX)
                           : prod_sh[DATA_W-1:0];
      scl_ovf   = scl_ff[SCALE_W-1:DATA_W-1] != {(SCALE_W-DATA_W+1){scl_ff[SCALE_W-1]}};
      scl_clip  = scl_ovf ? (scl_ff[SCALE_W-1] ? S32_MIN : S32_MAX) : scl_ff[DATA_W-1:0];
      sum       = {prod_clip[DATA_W-1], prod_clip} + {scl_clip[DATA_W-1], scl_clip};
      sum_ovf   = sum[DATA_W] != sum[DATA_W-1];
      sum_clip  = sum_ovf ? (sum[DATA_W] ? S32_MIN : S32_MAX) : sum[DATA_W-1:0];
   end

   always_comb begin
      acc_in = acc_ff;
      sat_in = sat_ff;
      if (ctrl.clear) begin
         acc_in = '0;
         sat_in = 1'b0;
      end else if (ctrl.add_en) begin
         acc_in = sum_clip;
         sat_in = sat_ff | prod_ovf | scl_ovf | sum_ovf;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
      sat_ff <= sat_in;
      if (ctrl.clear) begin
         x_ff <= x_in;
      end
      if (ctrl.mul_en) begin
         prod_ff <= acc_ff * x_ff;
         scl_ff  <= coef * $signed({1'b0, fact});
      end
   end

   assign acc = acc_ff;
   assign sat = sat_ff;

endmodule

// ===== sv/pde_seq.sv =====
// sequencer stepping the horner loop from the top coefficient down to the derivative order
// depends on pde_pkg
module pde_seq
   import pde_pkg::*;
#(
   parameter int NUM_COEFFS = NUM_COEFFS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_fire,
   input  logic [ORDER_W-1:0] req_order,
   input  logic               out_busy,
   output logic               req_ready,
   output coef_idx_type       k_idx,
   output logic [ORDER_W-1:0] order,
   output mac_ctrl_type       ctrl
);

   localparam coef_idx_type K_TOP = CSR_IDX_W'(NUM_COEFFS - 1);
   localparam logic [ORDER_W-1:0] N_ORDER = ORDER_W'(NUM_COEFFS);

   state_type            state_ff, state_in;
   coef_idx_type         k_ff, k_in;
   logic [ORDER_W-1:0]   d_ff, d_in;
   logic                 last_step;

   assign last_step = {1'b0, k_ff} == d_ff;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               state_in = (req_order >= N_ORDER) ? ST_DONE : ST_MUL;
            end
         end
         ST_MUL:  state_in = ST_ADD;
         ST_ADD:  state_in = last_step ? ST_DONE : ST_MUL;
         ST_DONE: begin
            if (!out_busy) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      k_in      = k_ff;
      d_in      = d_ff;
      ctrl      = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready  = 1'b1;
            ctrl.clear = req_fire;
            if (req_fire) begin
               k_in = K_TOP;
               d_in = req_order;
            end
         end
         ST_MUL:  ctrl.mul_en = 1'b1;
         ST_ADD: begin
            ctrl.add_en = 1'b1;
            if (!last_step) begin
               k_in = k_ff - 1'b1;
            end
         end
         ST_DONE: ctrl.out_load = !out_busy;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      k_ff <= k_in;
      d_ff <= d_in;
   end

   assign k_idx = k_ff;
   assign order = d_ff;

endmodule

// ===== sv/polynomial_derivative_eval.sv =====
// d-th derivative of an up to eight term Q16.16 polynomial by horner's rule
// a request is taken only in idle, so a new item waits until the previous result is loaded into the output
// register; each coefficient from the top one down to d takes a multiply step and a saturating add step in
// the shared multiply unit, and an order d >= NUM_COEFFS goes straight to the output with a zero result
// reset: synchronous, active high; clears coefficients to zero and the control state
// depends on pde_pkg, pde_coef_regs, pde_mac, pde_seq
module polynomial_derivative_eval
   import pde_pkg::*;
#(
   parameter int NUM_COEFFS = NUM_COEFFS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,   // sample_x[31:0], deriv_order[35:32], zero[39:36]
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [DATA_W-1:0]     rsp_tdata,   // value[31:0]
   output logic                  rsp_tuser,   // saturated
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [DATA_W-1:0]     csr_wdata
);

   logic                     req_fire;
   coef_idx_type             k_idx;
   logic [ORDER_W-1:0]       order;
   mac_ctrl_type             ctrl;
   logic signed [DATA_W-1:0] coef;
   logic [FACT_W-1:0]        fact;
   logic signed [DATA_W-1:0] acc;
   logic                     sat;
   logic                     out_busy;

   logic                     rsp_valid_ff, rsp_valid_in;
   logic [DATA_W-1:0]        rsp_value_ff;
   logic                     rsp_sat_ff;

   assign req_fire  = req_tvalid & req_tready;
   assign csr_ready = 1'b1;
   assign out_busy  = rsp_valid_ff & ~rsp_tready;
   assign fact      = falling_fact(k_idx, order);

   pde_coef_regs u_coef_regs (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (csr_valid & csr_ready),
      .wr_idx  (csr_index),
      .wr_data ($signed(csr_wdata)),
      .rd_idx  (k_idx),
      .rd_data (coef)
   );

   pde_seq #(
      .NUM_COEFFS (NUM_COEFFS)
   ) u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_fire  (req_fire),
      .req_order (req_tdata[DATA_W+ORDER_W-1:DATA_W]),
      .out_busy  (out_busy),
      .req_ready (req_tready),
      .k_idx     (k_idx),
      .order     (order),
      .ctrl      (ctrl)
   );

   pde_mac u_mac (
      .clock (clock),
      .ctrl  (ctrl),
      .x_in  ($signed(req_tdata[DATA_W-1:0])),
      .coef  (coef),
      .fact  (fact),
      .acc   (acc),
      .sat   (sat)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (ctrl.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (ctrl.out_load) begin
         rsp_value_ff <= acc;
         rsp_sat_ff   <= sat;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_value_ff;
   assign rsp_tuser  = rsp_sat_ff;

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 100ps
// self-checking bench for polynomial_derivative_eval: random and directed coefficient sets
// and sample points, each result checked against an in-bench horner predictor
// depends on pde_pkg and the polynomial_derivative_eval rtl
module tb_top;
   import pde_pkg::*;

   localparam int HALF_PERIOD = 2;
   localparam int RESET_CYCLES = 7;
   localparam int DRAIN_CYCLES = 2 * NUM_COEFFS_DEF + 4;
   localparam int STALL_CYCLES = 300;
   localparam int QUIET_LIMIT = 3000;
   localparam int RAND_SETS = 4;
   localparam int RAND_POINTS = 150;

   typedef logic [DATA_W-1:0] coef_set_type [NUM_COEFFS_DEF];

   typedef struct packed {
      logic [DATA_W-1:0] value;
      logic              sat;
   } deriv_result_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [DATA_W-1:0]     rsp_tdata;
   logic                  rsp_tuser;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [DATA_W-1:0]     csr_wdata = '0;

   longint           coef_model [NUM_COEFFS_DEF];
   deriv_result_type expected_derivs [$];
   int               error_count = 0;
   int               send_idle_pct = 0;
   int               recv_idle_pct = 0;
   logic             rsp_hold = 1'b0;
   int               quiet_cycles = 0;

   polynomial_derivative_eval i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #HALF_PERIOD clock = ~clock;

   function automatic longint clip_s32(input longint v, inout logic flag);
      if (v > longint'(S32_MAX)) begin
         flag = 1'b1;
         return longint'(S32_MAX);
      end
      if (v < longint'(S32_MIN)) begin
         flag = 1'b1;
         return longint'(S32_MIN);
      end
      return v;
   endfunction

   function automatic longint scaled_coef(input int k, input int d, inout logic flag);
      longint f;
      f = 1;
      for (int i = k - d + 1; i <= k; i++) begin
         f = f * i;
      end
      return clip_s32(coef_model[k] * f, flag);
   endfunction

   function automatic deriv_result_type eval_derivative(input logic [DATA_W-1:0] x_bits,
                                                        input logic [ORDER_W-1:0] order);
      deriv_result_type r;
      longint           acc;
      longint           xs;
      logic             flag;
      int               d;
      flag = 1'b0;
      acc = 0;
      xs = longint'($signed(x_bits));
      d = int'(order);
      if (d < NUM_COEFFS_DEF) begin
         acc = scaled_coef(NUM_COEFFS_DEF - 1, d, flag);
         for (int k = NUM_COEFFS_DEF - 2; k >= d; k--) begin
            acc = clip_s32((acc * xs) >>> FRAC_BITS, flag);
            acc = clip_s32(acc + scaled_coef(k, d, flag), flag);
         end
      end
      r.value = acc[DATA_W-1:0];
      r.sat = flag;
      return r;
   endfunction

   // result check, coefficient tracking and prediction of each accepted point
   always @(posedge clock) begin
      deriv_result_type exp_r;
      if (rsp_tvalid && rsp_tready) begin
         if (expected_derivs.size() == 0) begin
            $display("%0t: result with nothing expected, value %h sat %b",
                     $time, rsp_tdata, rsp_tuser);
            error_count++;
         end else begin
            exp_r = expected_derivs.pop_front();
            if (rsp_tdata !== exp_r.value) begin
               $display("%0t: value mismatch, expected %h actual %h",
                        $time, exp_r.value, rsp_tdata);
               error_count++;
            end
            if (rsp_tuser !== exp_r.sat) begin
               $display("%0t: saturated mismatch, expected %b actual %b",
                        $time, exp_r.sat, rsp_tuser);
               error_count++;
            end
         end
      end
      if (csr_valid && csr_ready) begin
         coef_model[csr_index] = longint'($signed(csr_wdata));
      end
      if (req_tvalid && req_tready) begin
         expected_derivs.push_back(eval_derivative(req_tdata[DATA_W-1:0],
                                                   req_tdata[DATA_W +: ORDER_W]));
      end
   end

   always @(negedge clock) begin
      rsp_tready <= !rsp_hold && ($urandom_range(99) >= recv_idle_pct);
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready) || reset) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("tb_top: errors");
         $finish;
      end
   end

   task automatic send_point(input logic [DATA_W-1:0] x, input logic [ORDER_W-1:0] order);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {{(REQ_DATA_W-DATA_W-ORDER_W){1'b0}}, order, x};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic load_coefs(input coef_set_type c);
      for (int i = 0; i < NUM_COEFFS_DEF; i++) begin
         csr_valid <= 1'b1;
         csr_index <= coef_idx_type'(i);
         csr_wdata <= c[i];
         @(posedge clock);
         while (!csr_ready) @(posedge clock);
         @(negedge clock);
      end
      csr_valid <= 1'b0;
   endtask

   task automatic drain;
      req_tvalid <= 1'b0;
      while (expected_derivs.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   function automatic logic [DATA_W-1:0] rand_coef();
      case ($urandom_range(9))
         0: return S32_MAX;
         1: return S32_MIN;
         2: return '0;
         3, 4: return $urandom;
         default: return DATA_W'(int'($urandom_range(32'h000F_FFFF)) - 32'sh0008_0000);
      endcase
   endfunction

   function automatic logic [DATA_W-1:0] rand_point();
      case ($urandom_range(7))
         0: return $urandom;
         1: begin
            case ($urandom_range(4))
               0: return S32_MAX;
               1: return S32_MIN;
               2: return 32'h0001_0000;
               3: return 32'hFFFF_0000;
               default: return '0;
            endcase
         end
         default: return DATA_W'(int'($urandom_range(32'h0003_FFFF)) - 32'sh0002_0000);
      endcase
   endfunction

   function automatic logic [ORDER_W-1:0] rand_order();
      if ($urandom_range(3) == 0) return ORDER_W'($urandom_range(15));
      return ORDER_W'($urandom_range(NUM_COEFFS_DEF));
   endfunction

   // all coefficients at reset value
   task automatic test_zero_coefs;
      send_point(S32_MAX, '0);
      send_point(S32_MIN, 4'hF);
      drain();
   endtask

   // ramp coefficients, every order including out of range ones
   task automatic test_all_orders;
      coef_set_type c;
      for (int i = 0; i < NUM_COEFFS_DEF; i++) c[i] = DATA_W'((i + 1) << FRAC_BITS);
      load_coefs(c);
      for (int d = 0; d <= NUM_COEFFS_DEF + 1; d++) begin
         send_point(DATA_W'(int'($urandom_range(32'h0003_FFFF)) - 32'sh0002_0000),
                    ORDER_W'(d));
      end
      send_point(32'h0001_0000, 4'hF);
      drain();
   endtask

   // full scale coefficients and points, clipping in scaling, product and sum
   task automatic test_coef_extremes;
      coef_set_type c;
      for (int i = 0; i < NUM_COEFFS_DEF; i++) c[i] = S32_MAX;
      load_coefs(c);
      send_point(S32_MAX, '0);
      send_point(S32_MIN, 4'd1);
      send_point(32'h0000_8000, 4'd7);
      drain();
      for (int i = 0; i < NUM_COEFFS_DEF; i++) c[i] = S32_MIN;
      load_coefs(c);
      send_point(S32_MAX, '0);
      send_point(S32_MIN, '0);
      send_point(32'hFFFF_8000, 4'd6);
      drain();
   endtask

   task automatic test_random_traffic(input int sender_pct, input int receiver_pct);
      coef_set_type c;
      send_idle_pct = sender_pct;
      recv_idle_pct = receiver_pct;
      for (int s = 0; s < RAND_SETS; s++) begin
         for (int i = 0; i < NUM_COEFFS_DEF; i++) c[i] = rand_coef();
         load_coefs(c);
         repeat (RAND_POINTS) send_point(rand_point(), rand_order());
         drain();
      end
   endtask

   // long receiver hold-off while points keep coming, input must back up
   task automatic test_output_stall;
      send_idle_pct = 0;
      recv_idle_pct = 0;
      fork
         begin
            @(posedge clock);
            rsp_hold = 1'b1;
            repeat (STALL_CYCLES) @(posedge clock);
            rsp_hold = 1'b0;
         end
         repeat (40) send_point(rand_point(), rand_order());
      join
      drain();
   endtask

   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      test_zero_coefs();
      test_all_orders();
      test_coef_extremes();
      test_random_traffic(34, 66);
      test_random_traffic(66, 34);
      test_random_traffic(0, 0);
      test_output_stall();
      if (error_count == 0) begin
         $display("tb_top: clean");
      end else begin
         $display("tb_top: errors");
      end
      $finish;
   end

   initial begin
      for (int i = 0; i < NUM_COEFFS_DEF; i++) coef_model[i] = 0;
   end

endmodule
